// File: rtl/core/lcdsfw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcdsfw_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  // value / 1000 == (value * 67109) >> 26 for every 16-bit value
  localparam logic [16:0] DIV1000_RECIP = 17'd67109;
  localparam int          DIV1000_SHIFT = 26;
  localparam logic [15:0] THOUSAND      = 16'd1000;

  localparam logic [4:0] SYNC_BITS   = 5'h1F;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_DISP_ON = 8'h0E;
  localparam logic [7:0] CMD_LINE_2  = 8'hA0;
  localparam logic [7:0] CMD_LINE_3  = 8'hC0;
  localparam logic [7:0] CMD_LINE_4  = 8'hE0;

  localparam logic [7:0] WRAP_AT_20 = 8'd20;
  localparam logic [7:0] WRAP_AT_40 = 8'd40;
  localparam logic [7:0] WRAP_AT_60 = 8'd60;

  localparam logic [2:0] INIT_LAST     = 3'd5;
  localparam logic [2:0] BYTE_DEC_LAST = 3'd2;
  localparam logic [2:0] NUM_DEC_LAST  = 3'd3;

  typedef enum logic [2:0] {
    ACT_CMD      = 3'd0,
    ACT_DATA     = 3'd1,
    ACT_CURSOR   = 3'd2,
    ACT_BYTE_DEC = 3'd3,
    ACT_NUM_DEC  = 3'd4,
    ACT_CLEAR    = 3'd5,
    ACT_INIT     = 3'd6,
    ACT_STR      = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    JOB_SINGLE   = 3'd0,
    JOB_PAIR     = 3'd1,
    JOB_INIT     = 3'd2,
    JOB_BYTE_DEC = 3'd3,
    JOB_NUM_DEC  = 3'd4
  } job_kind_t;

  typedef enum logic [1:0] {
    SCALE_100 = 2'd0,
    SCALE_10  = 2'd1,
    SCALE_1   = 2'd2
  } scale_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       rs0;
    logic       rs1;
    logic [7:0] data0;
    logic [7:0] data1;
    logic [9:0] rem;
  } job_t;

  typedef struct packed {
    logic [3:0] digit;
    logic [9:0] rest;
  } digit_t;

  // one decimal digit of rem (< 1000) at the given scale, by compare bank
  function automatic digit_t dec_digit(input logic [9:0] rem, input scale_t sc);
    digit_t res;
    res.digit = '0;
    res.rest  = rem;
    unique case (sc)
      SCALE_100: begin
        for (int k = 1; k <= 9; k++) begin
          if (rem >= 10'(k * 100)) begin
            res.digit = 4'(k);
            res.rest  = rem - 10'(k * 100);
          end
        end
      end
      SCALE_10: begin
        for (int k = 1; k <= 9; k++) begin
          if (rem >= 10'(k * 10)) begin
            res.digit = 4'(k);
            res.rest  = rem - 10'(k * 10);
          end
        end
      end
      default: begin
        res.digit = rem[3:0];
        res.rest  = '0;
      end
    endcase
    return res;
  endfunction

  function automatic logic [23:0] make_frame(input logic [7:0] b, input logic rs);
    return {4'h0, b[7:4], 4'h0, b[3:0], 1'b0, rs, 1'b0, SYNC_BITS};
  endfunction

  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h34;
      3'd1:    b = 8'h09;
      3'd2:    b = 8'h30;
      3'd3:    b = 8'h0F;
      3'd4:    b = 8'h01;
      default: b = 8'h07;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lcdsfw_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lcdsfw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        string_start;
  logic [15:0] value;

  modport source (output valid, output action, output string_start, output value,
                  input ready);
  modport sink (input valid, input action, input string_start, input value,
                output ready);
endinterface

`default_nettype wire

// File: rtl/core/lcdsfw_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lcdsfw_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] frame;
  logic        last;

  modport source (output valid, output frame, output last, input ready);
  modport sink (input valid, input frame, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lcdsfw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdsfw_front (
  input  logic               clk,
  input  logic               rst_n,
  lcdsfw_in_if.sink          in_ch,
  output lcdsfw_pkg::job_t   push_data,
  output logic               push_valid,
  input  logic               push_ready
);
  import lcdsfw_pkg::*;

  logic        accept;
  action_t     action_in;
  logic [7:0]  b_in;
  logic [32:0] prod;
  logic [6:0]  q_in;
  logic [7:0]  p_full;
  logic [7:0]  cnt_base;
  logic [7:0]  cnt_inc;
  logic        char_nz;
  logic        wrap_in;
  logic [7:0]  wrap_cmd_in;
  logic        emit_in;

  logic        a_valid_r;
  logic [7:0]  cnt_r;
  action_t     a_action_r;
  logic [7:0]  a_byte_r;
  logic [15:0] a_v_r;
  logic [6:0]  a_q_r;
  logic [6:0]  a_p_r;
  logic        a_wrap_r;
  logic [7:0]  a_wrap_cmd_r;
  logic        a_emit_r;

  logic        a_done;
  logic [1:0]  row;
  logic [4:0]  col;
  logic [6:0]  col_full;
  logic [15:0] thou;
  logic [15:0] rem_num;
  job_t        job;

  assign action_in = action_t'(in_ch.action);
  assign b_in      = in_ch.value[7:0];
  assign accept    = in_ch.valid && in_ch.ready;

  assign prod = {17'b0, in_ch.value} * {16'b0, DIV1000_RECIP};
  assign q_in = prod[DIV1000_SHIFT +: 7];

  always_comb begin
    if (b_in >= 8'd240) begin
      p_full = b_in - 8'd240;
    end else if (b_in >= 8'd160) begin
      p_full = b_in - 8'd160;
    end else if (b_in >= 8'd80) begin
      p_full = b_in - 8'd80;
    end else begin
      p_full = b_in;
    end
  end

  assign char_nz  = (b_in != 8'd0);
  assign cnt_base = in_ch.string_start ? 8'd0 : cnt_r;
  assign cnt_inc  = cnt_base + 8'd1;
  assign wrap_in  = char_nz &&
                    (cnt_inc == WRAP_AT_20 || cnt_inc == WRAP_AT_40 || cnt_inc == WRAP_AT_60);
  assign emit_in  = !(action_in == ACT_STR && !char_nz);

  always_comb begin
    if (cnt_inc == WRAP_AT_20) begin
      wrap_cmd_in = CMD_LINE_2;
    end else if (cnt_inc == WRAP_AT_40) begin
      wrap_cmd_in = CMD_LINE_3;
    end else begin
      wrap_cmd_in = CMD_LINE_4;
    end
  end

  assign push_valid  = a_valid_r && a_emit_r;
  assign a_done      = a_valid_r && (!a_emit_r || push_ready);
  assign in_ch.ready = !a_valid_r || a_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      cnt_r     <= 8'd0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (a_done) begin
        a_valid_r <= 1'b0;
      end
      if (accept && action_in == ACT_STR) begin
        cnt_r <= char_nz ? cnt_inc : cnt_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_action_r   <= action_in;
      a_byte_r     <= b_in;
      a_v_r        <= in_ch.value;
      a_q_r        <= q_in;
      a_p_r        <= p_full[6:0];
      a_wrap_r     <= wrap_in;
      a_wrap_cmd_r <= wrap_cmd_in;
      a_emit_r     <= emit_in;
    end
  end

  always_comb begin
    if (a_p_r >= 7'd60) begin
      row      = 2'd3;
      col_full = a_p_r - 7'd60;
    end else if (a_p_r >= 7'd40) begin
      row      = 2'd2;
      col_full = a_p_r - 7'd40;
    end else if (a_p_r >= 7'd20) begin
      row      = 2'd1;
      col_full = a_p_r - 7'd20;
    end else begin
      row      = 2'd0;
      col_full = a_p_r;
    end
  end

  assign col     = col_full[4:0];
  assign thou    = {9'b0, a_q_r} * THOUSAND;
  assign rem_num = a_v_r - thou;

  always_comb begin
    job.kind  = JOB_SINGLE;
    job.rs0   = 1'b0;
    job.rs1   = 1'b0;
    job.data0 = a_byte_r;
    job.data1 = a_wrap_cmd_r;
    job.rem   = {2'b0, a_byte_r};
    unique case (a_action_r)
      ACT_CMD: begin
        job.kind = JOB_SINGLE;
      end
      ACT_DATA: begin
        job.kind = JOB_SINGLE;
        job.rs0  = 1'b1;
      end
      ACT_CURSOR: begin
        job.kind  = JOB_SINGLE;
        job.data0 = {1'b1, row, col};
      end
      ACT_BYTE_DEC: begin
        job.kind = JOB_BYTE_DEC;
      end
      ACT_NUM_DEC: begin
        job.kind  = JOB_NUM_DEC;
        job.data0 = ASCII_ZERO + {1'b0, a_q_r};
        job.rem   = rem_num[9:0];
      end
      ACT_CLEAR: begin
        job.kind  = JOB_PAIR;
        job.data0 = CMD_CLEAR;
        job.data1 = CMD_DISP_ON;
      end
      ACT_INIT: begin
        job.kind = JOB_INIT;
      end
      default: begin
        job.kind = a_wrap_r ? JOB_PAIR : JOB_SINGLE;
        job.rs0  = 1'b1;
      end
    endcase
  end

  assign push_data = job;

endmodule

`default_nettype wire

// File: rtl/core/lcdsfw_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdsfw_queue #(
  parameter int DEPTH = lcdsfw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  lcdsfw_pkg::job_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output lcdsfw_pkg::job_t pop_data
);
  import lcdsfw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lcdsfw_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdsfw_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  lcdsfw_pkg::job_t pop_data,
  lcdsfw_out_if.source     out_ch
);
  import lcdsfw_pkg::*;

  logic        active_r;
  job_t        job_r;
  logic [2:0]  step_r;
  logic [9:0]  rem_r;
  logic        out_valid_r;
  logic [23:0] out_frame_r;
  logic        out_last_r;

  logic        issue;
  logic        load;
  logic [7:0]  cur_byte;
  logic        cur_rs;
  logic        cur_last;
  scale_t      sc;
  digit_t      dig;
  logic [7:0]  dig_char;
  logic [9:0]  rem_upd;

  assign dig      = dec_digit(rem_r, sc);
  assign dig_char = ASCII_ZERO + {4'b0, dig.digit};

  always_comb begin
    cur_byte = job_r.data0;
    cur_rs   = job_r.rs0;
    cur_last = 1'b1;
    sc       = SCALE_1;
    rem_upd  = dig.rest;
    unique case (job_r.kind)
      JOB_SINGLE: begin
        cur_last = 1'b1;
      end
      JOB_PAIR: begin
        cur_byte = (step_r == 3'd0) ? job_r.data0 : job_r.data1;
        cur_rs   = (step_r == 3'd0) ? job_r.rs0 : job_r.rs1;
        cur_last = (step_r != 3'd0);
      end
      JOB_INIT: begin
        cur_byte = init_byte(step_r);
        cur_rs   = 1'b0;
        cur_last = (step_r == INIT_LAST);
      end
      JOB_BYTE_DEC: begin
        sc       = (step_r == 3'd0) ? SCALE_100 : ((step_r == 3'd1) ? SCALE_10 : SCALE_1);
        cur_byte = dig_char;
        cur_rs   = 1'b1;
        cur_last = (step_r == BYTE_DEC_LAST);
      end
      JOB_NUM_DEC: begin
        sc       = (step_r == 3'd1) ? SCALE_100 : ((step_r == 3'd2) ? SCALE_10 : SCALE_1);
        cur_byte = (step_r == 3'd0) ? job_r.data0 : dig_char;
        cur_rs   = 1'b1;
        cur_last = (step_r == NUM_DEC_LAST);
        rem_upd  = (step_r == 3'd0) ? rem_r : dig.rest;
      end
      default: begin
        cur_last = 1'b1;
      end
    endcase
  end

  assign issue     = active_r && (!out_valid_r || out_ch.ready);
  assign pop_ready = !active_r || (issue && cur_last);
  assign load      = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        active_r <= 1'b1;
      end else if (issue && cur_last) begin
        active_r <= 1'b0;
      end
      if (issue) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r  <= pop_data;
      step_r <= 3'd0;
      rem_r  <= pop_data.rem;
    end else if (issue) begin
      step_r <= step_r + 3'd1;
      rem_r  <= rem_upd;
    end
    if (issue) begin
      out_frame_r <= make_frame(cur_byte, cur_rs);
      out_last_r  <= cur_last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.frame = out_frame_r;
  assign out_ch.last  = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/char_lcd_serial_frame_writer.sv
`timescale 1ns / 1ps
`default_nettype none

// Serial frame writer for a 4x20 character LCD. Each request on in_ch (raw
// command or data, cursor, byte or number in decimal, clear, init, string
// character) becomes one to six 24-bit frames on out_ch, bit 0 meant to be
// shifted first, with last set on the final frame of the request; a zero
// string character gives no frame. The front takes one request per cycle
// (unless the queue is full) into a classify stage and a QUEUE_DEPTH-entry
// queue; the back emits one frame per cycle while out_ch is ready, and the
// back's single frame port sets the sustained rate. Requests pass the
// classify stage, queue and job register; output frames are registered.
module char_lcd_serial_frame_writer #(
  parameter int QUEUE_DEPTH = lcdsfw_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  lcdsfw_in_if.sink    in_ch,
  lcdsfw_out_if.source out_ch
);
  import lcdsfw_pkg::*;

  job_t push_data;
  logic push_valid;
  logic push_ready;
  job_t pop_data;
  logic pop_valid;
  logic pop_ready;

  lcdsfw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  lcdsfw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lcdsfw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// File: dv/tb_char_lcd_serial_frame_writer.sv
`timescale 1ns / 1ps

import lcdsfw_pkg::*;

typedef struct {
  logic [23:0] frame;
  logic        last;
} lcd_frame_t;

class frame_scoreboard;
  lcd_frame_t  expected_frames[$];
  logic [7:0]  char_count;
  int          requests;
  int          frames_checked;
  int          wrap_cmds;
  int          mismatches;

  function new();
    char_count     = 8'd0;
    requests       = 0;
    frames_checked = 0;
    wrap_cmds      = 0;
    mismatches     = 0;
  endfunction

  function logic [23:0] build_frame(input logic [7:0] b, input logic rs);
    logic [23:0] f;
    f = 24'h00001F + (24'(b[3:0]) << 8) + (24'(b[7:4]) << 16);
    if (rs) f = f + 24'h000040;
    return f;
  endfunction

  function logic [7:0] line_cmd(input logic [7:0] pos);
    logic [7:0] p;
    p = pos % 8'd80;
    return 8'h80 + (p / 8'd20) * 8'h20 + (p % 8'd20);
  endfunction

  function void push_frame(input logic [7:0] b, input logic rs);
    lcd_frame_t e;
    e.frame = build_frame(b, rs);
    e.last  = 1'b0;
    expected_frames.push_back(e);
  endfunction

  function void note_request(input action_t act, input logic st, input logic [15:0] v);
    int          n0;
    logic [7:0]  b;
    logic [15:0] r;
    n0 = expected_frames.size();
    b  = v[7:0];
    requests++;
    case (act)
      ACT_CMD:    push_frame(b, 1'b0);
      ACT_DATA:   push_frame(b, 1'b1);
      ACT_CURSOR: push_frame(line_cmd(b), 1'b0);
      ACT_BYTE_DEC: begin
        push_frame(8'h30 + b / 8'd100, 1'b1);
        push_frame(8'h30 + (b % 8'd100) / 8'd10, 1'b1);
        push_frame(8'h30 + b % 8'd10, 1'b1);
      end
      ACT_NUM_DEC: begin
        r = v % 16'd1000;
        push_frame(8'h30 + 8'(v / 16'd1000), 1'b1);
        push_frame(8'h30 + 8'(r / 16'd100), 1'b1);
        push_frame(8'h30 + 8'((r % 16'd100) / 16'd10), 1'b1);
        push_frame(8'h30 + 8'(r % 16'd10), 1'b1);
      end
      ACT_CLEAR: begin
        push_frame(8'h01, 1'b0);
        push_frame(8'h0E, 1'b0);
      end
      ACT_INIT: begin
        push_frame(8'h34, 1'b0);
        push_frame(8'h09, 1'b0);
        push_frame(8'h30, 1'b0);
        push_frame(8'h0F, 1'b0);
        push_frame(8'h01, 1'b0);
        push_frame(8'h07, 1'b0);
      end
      default: begin
        if (st) char_count = 8'd0;
        if (b != 8'd0) begin
          push_frame(b, 1'b1);
          char_count = char_count + 8'd1;
          if (char_count == 8'd20 || char_count == 8'd40 || char_count == 8'd60) begin
            push_frame(line_cmd(char_count), 1'b0);
            wrap_cmds++;
          end
        end
      end
    endcase
    if (expected_frames.size() > n0)
      expected_frames[expected_frames.size() - 1].last = 1'b1;
  endfunction

  function void check_frame(input logic [23:0] f, input logic l);
    lcd_frame_t e;
    frames_checked++;
    if (expected_frames.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected frame %h last %b", $realtime, f, l);
      mismatches++;
      return;
    end
    e = expected_frames.pop_front();
    if (f !== e.frame || l !== e.last) begin
      if (mismatches < 10)
        $display("%0t: frame mismatch: expected frame %h last %b, got frame %h last %b",
                 $realtime, e.frame, e.last, f, l);
      mismatches++;
    end
  endfunction

  function int pending();
    return expected_frames.size();
  endfunction
endclass

module tb_char_lcd_serial_frame_writer;
  logic clk = 1'b0;
  logic rst_n;

  lcdsfw_in_if  in_ch();
  lcdsfw_out_if out_ch();

  char_lcd_serial_frame_writer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_scoreboard sb;
  int sent_count;
  int rx_count;
  int counted_random;

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_request(input action_t act, input logic st, input logic [15:0] v);
    int gap;
    gap = ((sent_count % 64) < 12) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.string_start <= st;
    in_ch.value        <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(act, st, v);
    sent_count++;
  endtask

  // nonzero low byte, random high byte
  function automatic logic [15:0] rand_char();
    return {8'($urandom_range(0, 255)), 8'($urandom_range(1, 255))};
  endfunction

  // result side: random stalls, one long hold-off to back up the input
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_count == 40) gap = 100;
      else if ((rx_count % 80) < 15) gap = 0;
      else gap = $urandom_range(0, 18);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.check_frame(out_ch.frame, out_ch.last);
      rx_count++;
    end
  end

  initial begin
    int   len;
    logic st;
    sb             = new();
    sent_count     = 0;
    rx_count       = 0;
    counted_random = 0;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_CMD;
    in_ch.string_start <= 1'b0;
    in_ch.value        <= 16'h0000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(ACT_CMD, 1'b1, 16'h0000);
    send_request(ACT_CMD, 1'b0, 16'h00FF);
    send_request(ACT_DATA, 1'b0, 16'h0000);
    send_request(ACT_DATA, 1'b1, 16'hFFFF);
    send_request(ACT_CURSOR, 1'b0, 16'h0000);
    send_request(ACT_CURSOR, 1'b0, 16'd19);
    send_request(ACT_CURSOR, 1'b0, 16'd20);
    send_request(ACT_CURSOR, 1'b0, 16'd79);
    send_request(ACT_CURSOR, 1'b0, 16'd80);
    send_request(ACT_CURSOR, 1'b1, 16'hFFFF);
    send_request(ACT_BYTE_DEC, 1'b0, 16'h0000);
    send_request(ACT_BYTE_DEC, 1'b0, 16'hFFFF);
    send_request(ACT_NUM_DEC, 1'b0, 16'd0);
    send_request(ACT_NUM_DEC, 1'b0, 16'd9999);
    send_request(ACT_NUM_DEC, 1'b0, 16'd10000);
    send_request(ACT_NUM_DEC, 1'b1, 16'hFFFF);
    send_request(ACT_CLEAR, 1'b0, 16'h0000);
    send_request(ACT_INIT, 1'b0, 16'hFFFF);
    send_request(ACT_STR, 1'b1, 16'h0041);
    send_request(ACT_STR, 1'b0, 16'hFF00);
    send_request(ACT_STR, 1'b1, 16'h0000);
    send_request(ACT_STR, 1'b0, 16'h0042);

    // random actions and short strings, some continuing the previous count
    while (counted_random < 20) begin
      if ($urandom_range(0, 9) < 4) begin
        len = $urandom_range(1, 6);
        st  = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < len; k++) begin
          send_request(ACT_STR, (k == 0) ? st : 1'($urandom_range(0, 1)), rand_char());
          counted_random++;
        end
        if ($urandom_range(0, 2) == 0)
          send_request(ACT_STR, 1'($urandom_range(0, 1)), {8'($urandom_range(0, 255)), 8'h00});
      end else begin
        send_request(action_t'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     16'($urandom_range(0, 65535)));
        counted_random++;
      end
    end

    // one string long enough to reach all three line wraps
    for (int k = 0; k < 62; k++)
      send_request(ACT_STR, (k == 0), rand_char());

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.pending() != 0) begin
      $display("%0d expected frames never arrived", sb.pending());
      sb.mismatches++;
    end
    $display("Ran %0d requests over all actions, %0d frames checked, %0d line wrap commands",
             sb.requests, sb.frames_checked, sb.wrap_cmds);
    $display("All three line wraps, decimal extremes and a long output stall included");
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
